/* hdl/lwtc_pkg.sv */
// Shared types and constants for the level-wind traverse controller.
// Depends on nothing; the interfaces and the top level import it.
package lwtc_pkg;

  // Payload widths of the channel fields and configuration registers.
  localparam int REQ_W     = 2;
  localparam int TICK_W    = 7;
  localparam int DUTY_W    = 16;
  localparam int DRIVE_W   = 2;
  localparam int POS_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int MULT_W    = 4;
  localparam int PROD_W    = DUTY_W + MULT_W;
  localparam int RECIP_W   = 20;
  localparam int RECIP_SH  = 23;

  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [DRIVE_W-1:0]   drive_t;
  typedef logic [DUTY_W-1:0]    duty_t;
  typedef logic [TICK_W-1:0]    tick_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;
  typedef logic [1:0]           cmd_t;
  typedef logic [1:0]           duty_op_t;

  // Event kinds.
  localparam req_t REQ_OPTO_ONE = 2'd0;
  localparam req_t REQ_OPTO_TWO = 2'd1;
  localparam req_t REQ_CARRIAGE = 2'd2;
  localparam req_t REQ_TICK     = 2'd3;

  // Bridge drive codes.
  localparam drive_t DRV_STOP  = 2'd0;
  localparam drive_t DRV_LEFT  = 2'd1;
  localparam drive_t DRV_RIGHT = 2'd2;
  localparam drive_t DRV_BRAKE = 2'd3;

  // Command bits.
  localparam cmd_t CMD_RELEASE = 2'b01;
  localparam cmd_t CMD_PULL    = 2'b10;

  // Register indexes.
  localparam cfg_idx_t REG_SPOOL_TICKS    = 3'd0;
  localparam cfg_idx_t REG_CARRIAGE_TICKS = 3'd1;
  localparam cfg_idx_t REG_DECEL_START    = 3'd2;
  localparam cfg_idx_t REG_PWM_PERIOD     = 3'd3;
  localparam cfg_idx_t REG_OPTO_OFF       = 3'd4;

  // What the output stage does with the duty word.
  localparam duty_op_t DOP_HOLD  = 2'd0;
  localparam duty_op_t DOP_FULL  = 2'd1;
  localparam duty_op_t DOP_ZERO  = 2'd2;
  localparam duty_op_t DOP_SCALE = 2'd3;

  localparam duty_t FULL_DUTY  = 16'hFFFF;
  localparam int    DUTY_STEPS = 10;
  // Reciprocal of ten, exact for products below 2^22.
  localparam logic [RECIP_W-1:0] RECIP_TEN = 20'hCCCCD;

  // Reset values of the registers.
  localparam tick_t RST_SPOOL_TICKS    = 7'd20;
  localparam tick_t RST_CARRIAGE_TICKS = 7'd20;
  localparam tick_t RST_DECEL_START    = 7'd10;
  localparam duty_t RST_PWM_PERIOD     = 16'hFFFF;

endpackage

/* hdl/lwtc_ifs.sv */
// Valid/ready channel interfaces for event words and result words.
// Depends on lwtc_pkg.
interface lwtc_in_if;
  import lwtc_pkg::*;
  logic valid;
  logic ready;
  req_t req_type;
  logic opto_one_level;
  logic opto_two_level;
  logic limit_one;
  logic limit_two;

  modport source (output valid, req_type, opto_one_level, opto_two_level,
                  limit_one, limit_two, input ready);
  modport sink   (input valid, req_type, opto_one_level, opto_two_level,
                  limit_one, limit_two, output ready);
endinterface

interface lwtc_out_if;
  import lwtc_pkg::*;
  logic   valid;
  logic   ready;
  duty_t  duty_compare;
  drive_t drive_code;
  logic   run_active;

  modport source (output valid, duty_compare, drive_code, run_active, input ready);
  modport sink   (input valid, duty_compare, drive_code, run_active, output ready);
endinterface

/* hdl/level_wind_traverse_controller.sv */
// Level-wind traverse controller: spool and carriage counting, command
// posting and the traverse task on control ticks. Depends on lwtc_pkg, lwtc_ifs.
// Event words pass the s1, s2 and output registers; a low out_if.ready stalls.
// Throughput: one word per cycle unless stalled; duty scaling is split over two
// registered multiplies (period times steps, then times one tenth).
// Reset (synchronous, rst_n low) restores the register defaults and clears
// all counters, posted commands and the task; the duty output resets to zero.
module level_wind_traverse_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  lwtc_pkg::cfg_idx_t  cfg_index,
  input  lwtc_pkg::cfg_dat_t  cfg_wdata,
  lwtc_in_if.sink             in_if,
  lwtc_out_if.source          out_if
);
  import lwtc_pkg::*;

  // Configuration registers.
  tick_t spool_ticks_r, carriage_ticks_r, decel_start_r;
  duty_t pwm_period_r;
  logic  opto_off_r;

  // Controller state.
  logic [POS_W-1:0] spool_pos_r, spool_pos_nxt;
  logic [POS_W-1:0] carr_pos_r, carr_pos_nxt;
  logic   run_en_r, run_en_nxt;
  cmd_t   pending_r, pending_nxt;
  logic   moving_r, moving_nxt;
  cmd_t   held_r, held_nxt;
  cmd_t   prev_r, prev_nxt;
  drive_t dir_r, dir_nxt;
  drive_t drive_r, drive_nxt;

  // Pipeline registers.
  logic              s1_valid_r, s2_valid_r, out_valid_r;
  duty_op_t          s1_op_r, s2_op_r, dop_nxt;
  logic [MULT_W-1:0] s1_mult_r, mult_nxt;
  duty_t             s1_period_r;
  drive_t            s1_drive_r, s2_drive_r;
  logic              s1_run_r, s2_run_r;
  logic [PROD_W-1:0] s2_prod_r;
  duty_t             out_duty_r;
  drive_t            out_drive_r;
  logic              out_run_r;

  logic advance, accept;
  logic [POS_W-1:0] spool_inc, spool_dec, carr_inc;
  logic signed [POS_W+1:0] decel_k;
  logic take, pass_on, both_lim;
  cmd_t held_eff;
  logic [RECIP_W+PROD_W-1:0] scaled;

  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = advance;
  assign accept      = in_if.valid && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spool_ticks_r    <= RST_SPOOL_TICKS;
      carriage_ticks_r <= RST_CARRIAGE_TICKS;
      decel_start_r    <= RST_DECEL_START;
      pwm_period_r     <= RST_PWM_PERIOD;
      opto_off_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPOOL_TICKS:    spool_ticks_r    <= cfg_wdata[TICK_W-1:0];
        REG_CARRIAGE_TICKS: carriage_ticks_r <= cfg_wdata[TICK_W-1:0];
        REG_DECEL_START:    decel_start_r    <= cfg_wdata[TICK_W-1:0];
        REG_PWM_PERIOD:     pwm_period_r     <= cfg_wdata[DUTY_W-1:0];
        REG_OPTO_OFF:       opto_off_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign spool_inc = spool_pos_r + 1'b1;
  assign spool_dec = spool_pos_r - 1'b1;
  assign carr_inc  = carr_pos_r + 1'b1;
  assign decel_k   = $signed({{2{carr_pos_r[POS_W-1]}}, carr_pos_r})
                   - $signed({3'b000, decel_start_r});

  // A tick with nothing running picks up the posted commands first.
  assign take     = !moving_r && (pending_r != 2'b00);
  assign held_eff = take ? pending_r : held_r;
  assign both_lim = in_if.limit_one && in_if.limit_two;
  assign pass_on  = run_en_r && !both_lim;

  always_comb begin
    spool_pos_nxt = spool_pos_r;
    carr_pos_nxt  = carr_pos_r;
    run_en_nxt    = run_en_r;
    pending_nxt   = pending_r;
    moving_nxt    = moving_r;
    held_nxt      = held_r;
    prev_nxt      = prev_r;
    dir_nxt       = dir_r;
    drive_nxt     = drive_r;
    dop_nxt       = DOP_HOLD;
    mult_nxt      = 4'(DUTY_STEPS - decel_k);
    case (in_if.req_type)
      REQ_OPTO_ONE: begin
        if (in_if.opto_two_level == opto_off_r) begin
          if ($signed({spool_inc[POS_W-1], spool_inc}) >
              $signed({2'b00, spool_ticks_r})) begin
            spool_pos_nxt = '0;
            run_en_nxt    = 1'b1;
            pending_nxt   = pending_r | CMD_RELEASE;
          end else begin
            spool_pos_nxt = spool_inc;
          end
        end
      end
      REQ_OPTO_TWO: begin
        if (in_if.opto_one_level == opto_off_r) begin
          if ($signed({spool_dec[POS_W-1], spool_dec}) <
              -$signed({2'b00, spool_ticks_r})) begin
            spool_pos_nxt = '0;
            run_en_nxt    = 1'b1;
            pending_nxt   = pending_r | CMD_PULL;
          end else begin
            spool_pos_nxt = spool_dec;
          end
        end
      end
      REQ_CARRIAGE: begin
        if ($signed({carr_inc[POS_W-1], carr_inc}) >
            $signed({2'b00, carriage_ticks_r})) begin
          carr_pos_nxt = '0;
          run_en_nxt   = 1'b0;
        end else begin
          carr_pos_nxt = carr_inc;
        end
      end
      REQ_TICK: begin
        if (take) begin
          held_nxt    = pending_r;
          pending_nxt = 2'b00;
        end
        if (moving_r || take) begin
          if (pass_on) begin
            moving_nxt = 1'b1;
            if (decel_k <= 0) begin
              dop_nxt = DOP_FULL;
            end else if (decel_k >= DUTY_STEPS) begin
              dop_nxt = DOP_ZERO;
            end else begin
              dop_nxt = DOP_SCALE;
            end
            if (in_if.limit_one) begin
              dir_nxt = DRV_RIGHT;
            end else if (in_if.limit_two) begin
              dir_nxt = DRV_LEFT;
            end else if (held_eff != prev_r) begin
              prev_nxt = held_eff;
              dir_nxt  = (dir_r == DRV_LEFT) ? DRV_RIGHT : DRV_LEFT;
            end
            drive_nxt = dir_nxt;
          end else begin
            // Run disabled before or by this pass: brake and go idle.
            if (run_en_r) begin
              dir_nxt    = DRV_STOP;
              run_en_nxt = 1'b0;
            end
            moving_nxt = 1'b0;
            dop_nxt    = DOP_FULL;
            drive_nxt  = DRV_BRAKE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spool_pos_r <= '0;
      carr_pos_r  <= '0;
      run_en_r    <= 1'b0;
      pending_r   <= 2'b00;
      moving_r    <= 1'b0;
      held_r      <= CMD_RELEASE;
      prev_r      <= CMD_RELEASE;
      dir_r       <= DRV_STOP;
      drive_r     <= DRV_STOP;
    end else if (accept) begin
      spool_pos_r <= spool_pos_nxt;
      carr_pos_r  <= carr_pos_nxt;
      run_en_r    <= run_en_nxt;
      pending_r   <= pending_nxt;
      moving_r    <= moving_nxt;
      held_r      <= held_nxt;
      prev_r      <= prev_nxt;
      dir_r       <= dir_nxt;
      drive_r     <= drive_nxt;
    end
  end

  // Valid bits of the three stages; all stages move together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_if.valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r     <= dop_nxt;
      s1_mult_r   <= mult_nxt;
      s1_period_r <= pwm_period_r;
      s1_drive_r  <= drive_nxt;
      s1_run_r    <= run_en_nxt;
      s2_op_r     <= s1_op_r;
      s2_prod_r   <= PROD_W'(s1_period_r) * PROD_W'(s1_mult_r);
      s2_drive_r  <= s1_drive_r;
      s2_run_r    <= s1_run_r;
    end
  end

  assign scaled = (RECIP_W+PROD_W)'(s2_prod_r) * (RECIP_W+PROD_W)'(RECIP_TEN);

  // The output duty word doubles as the held duty between passes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_duty_r <= '0;
    end else if (advance && s2_valid_r) begin
      case (s2_op_r)
        DOP_FULL:  out_duty_r <= FULL_DUTY;
        DOP_ZERO:  out_duty_r <= '0;
        DOP_SCALE: out_duty_r <= scaled[RECIP_SH+DUTY_W-1:RECIP_SH];
        default:   out_duty_r <= out_duty_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid_r) begin
      out_drive_r <= s2_drive_r;
      out_run_r   <= s2_run_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.duty_compare = out_duty_r;
  assign out_if.drive_code   = out_drive_r;
  assign out_if.run_active   = out_run_r;

endmodule
